// ===== design/mbsm_pkg.sv =====
// Shared constants and types for the masked byte signature matcher.
`timescale 1ns / 1ps

package mbsm_pkg;

  // Longest signature that the window can hold.
  localparam int unsigned MAX_SIG_BYTES = 16;
  localparam int unsigned WIN_IDX_W     = $clog2(MAX_SIG_BYTES);

  // Widths of the register and stream fields.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CMP_EN_W = 16;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMP_EN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_LEN  = 2'd3;

  // What a window cell compares its byte against.
  typedef struct packed {
    logic              care;
    logic [BYTE_W-1:0] exp_byte;
  } cmp_t;

  // Per-cycle control handed down the row of cells.
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== design/mbsm_cell.sv =====
// One window cell: holds a byte of history, shifts it on, and compares it.
`timescale 1ns / 1ps

module mbsm_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mbsm_pkg::cell_ctrl_t            ctrl,
  input  logic [mbsm_pkg::BYTE_W-1:0]     byte_in,
  input  mbsm_pkg::cmp_t                  cmp,
  output logic [mbsm_pkg::BYTE_W-1:0]     byte_out,
  output logic                            miss
);

  logic [mbsm_pkg::BYTE_W-1:0] byte_r;
  logic [mbsm_pkg::BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.advance) begin
      byte_nxt = ctrl.clear ? '0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // The stored byte is the one the incoming word pushes one place further on.
  assign byte_out = byte_r;
  assign miss     = cmp.care && (byte_r != cmp.exp_byte);

endmodule

// ===== design/masked_byte_signature_matcher.sv =====
// Top level of the masked byte signature matcher.
`timescale 1ns / 1ps

// The input stream carries a buffer one byte per word, with in_tlast on the
// final byte. The block searches it for a signature of up to sixteen bytes,
// each byte either compared or a wildcard, as set by the configuration port
// (write enable, register index, data; writes land in the next cycle).
// Exactly one result word leaves per buffer: found with the start offset of
// the first match, sent on the word that completes the match, or not-found
// with offset zero on the final byte. A zero-length signature matches at
// offset zero on the first byte. A match never spans two buffers.
// The byte history lives in a row of cells that shift once per accepted
// word; each cell compares its byte against the aligned signature byte.
// The result is registered: it appears in the cycle after the word that caused
// it. One word is taken every cycle while the output is taken or empty;
// the single output register is what limits the rate when the receiver
// stalls, as in_tready then drops until the waiting result is taken.
// Synchronous reset clears the signature registers, the window, the byte
// position and the reported flag, and empties the output register.

module masked_byte_signature_matcher (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // last_byte
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // [31:0] match_offset
  output logic [0:0]                          out_tuser,  // [0] found
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [mbsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbsm_pkg::WORD_W-1:0]         cfg_data
);

  localparam int unsigned NCELLS = mbsm_pkg::MAX_SIG_BYTES - 1;

  // Configuration registers
  logic [mbsm_pkg::WORD_W-1:0]   sig_lo_r;
  logic [mbsm_pkg::WORD_W-1:0]   sig_hi_r;
  logic [mbsm_pkg::CMP_EN_W-1:0] cmp_en_r;
  logic [mbsm_pkg::LEN_W-1:0]    sig_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_lo_r  <= '0;
      sig_hi_r  <= '0;
      cmp_en_r  <= '0;
      sig_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbsm_pkg::CFG_SIG_LOW:  sig_lo_r  <= cfg_data;
        mbsm_pkg::CFG_SIG_HIGH: sig_hi_r  <= cfg_data;
        mbsm_pkg::CFG_CMP_EN:   cmp_en_r  <= cfg_data[mbsm_pkg::CMP_EN_W-1:0];
        mbsm_pkg::CFG_SIG_LEN:  sig_len_r <= cfg_data[mbsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the window size are treated as the full window.
  logic [mbsm_pkg::LEN_W-1:0] len_c;
  assign len_c = (sig_len_r > mbsm_pkg::LEN_W'(mbsm_pkg::MAX_SIG_BYTES)) ?
                 mbsm_pkg::LEN_W'(mbsm_pkg::MAX_SIG_BYTES) : sig_len_r;

  logic [mbsm_pkg::MAX_SIG_BYTES-1:0][mbsm_pkg::BYTE_W-1:0] sig_bytes;
  assign sig_bytes = {sig_hi_r, sig_lo_r};

  // Align the signature to the window: window place j (j bytes ago, counting
  // the incoming byte as place zero) meets signature byte len-1-j.
  mbsm_pkg::cmp_t [mbsm_pkg::MAX_SIG_BYTES-1:0] cmp_win;

  for (genvar j = 0; j < mbsm_pkg::MAX_SIG_BYTES; j++) begin : g_align
    logic [mbsm_pkg::LEN_W-1:0]     sel;
    logic [mbsm_pkg::WIN_IDX_W-1:0] sel_idx;
    logic                           in_use;
    assign sel     = len_c - mbsm_pkg::LEN_W'(j + 1);
    assign sel_idx = sel[mbsm_pkg::WIN_IDX_W-1:0];
    assign in_use  = mbsm_pkg::LEN_W'(j) < len_c;
    assign cmp_win[j].care     = in_use && cmp_en_r[sel_idx];
    assign cmp_win[j].exp_byte = sig_bytes[sel_idx];
  end

  // Handshake and control
  logic                     out_valid_r;
  logic                     accept;
  mbsm_pkg::cell_ctrl_t     cell_ctrl;

  assign in_tready       = !out_valid_r || out_tready;
  assign accept          = in_tvalid && in_tready;
  assign cell_ctrl.advance = accept;
  assign cell_ctrl.clear   = in_tlast;

  // Row of window cells. win_byte[0] is the incoming byte; cell k holds window
  // place k+1, the byte that came k+1 accepted words before the incoming one.
  logic [mbsm_pkg::MAX_SIG_BYTES-1:0][mbsm_pkg::BYTE_W-1:0] win_byte;
  logic [mbsm_pkg::MAX_SIG_BYTES-1:0]                       win_miss;

  assign win_byte[0] = in_tdata;
  assign win_miss[0] = cmp_win[0].care && (in_tdata != cmp_win[0].exp_byte);

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    mbsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .byte_in  (win_byte[k]),
      .cmp      (cmp_win[k+1]),
      .byte_out (win_byte[k+1]),
      .miss     (win_miss[k+1])
    );
  end

  // Buffer position and match state
  logic [mbsm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       reported_r, reported_nxt;
  logic [mbsm_pkg::POS_W-1:0] span;
  logic                       hit;
  logic                       produce;
  logic [mbsm_pkg::POS_W-1:0] offset;

  assign span = mbsm_pkg::POS_W'(len_c) - mbsm_pkg::POS_W'(1);

  always_comb begin
    if (len_c == '0) begin
      hit    = 1'b1;
      offset = '0;
    end else begin
      hit    = (pos_r >= span) && (win_miss == '0);
      offset = pos_r - span;
    end
  end

  assign produce = accept && !reported_r && (hit || in_tlast);

  always_comb begin
    pos_nxt      = pos_r;
    reported_nxt = reported_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt      = '0;
        reported_nxt = 1'b0;
      end else begin
        if (pos_r != '1) begin
          pos_nxt = pos_r + mbsm_pkg::POS_W'(1);
        end
        if (!reported_r && hit) begin
          reported_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      reported_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      reported_r <= reported_nxt;
    end
  end

  // Output register
  logic        found_r;
  logic [31:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      found_r  <= hit;
      offset_r <= hit ? offset : '0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = offset_r;
  assign out_tuser[0] = found_r;

endmodule

// ===== design/mbsm_checker.sv =====
// Port-level checks for the masked byte signature matcher, bound to the top.
`timescale 1ns / 1ps

module mbsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A result waiting on the receiver holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A not-found word always carries a zero offset.
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0)
    else $error("not-found word with non-zero offset");

  // A fresh result only follows an accepted input word.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result word without an input word");

  // With nothing waiting at the output, input is never refused.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with empty output");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word survived reset");

endmodule

bind masked_byte_signature_matcher mbsm_checker u_mbsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/masked_byte_signature_matcher_test.sv =====
// Self-checking testbench for the masked byte signature matcher.
`timescale 1ns / 1ps

// The testbench feeds buffers into the matcher one byte per word and keeps its
// own model of the search alongside. That model holds the byte history, the
// position within the buffer and the reported flag, so it can work out the
// result that each accepted word should give. Each expected result is queued
// and compared, field by field, with the next result word that the block
// hands over.
//
// The run has two parts. A short directed table comes first: the cleared
// registers after reset, a three-byte signature found at an offset, a match
// cut short by the end of the buffer, and a length above sixteen with
// wildcards in the middle. Random phases follow. Each phase writes all four
// registers, and the first few phases use the extreme settings. Most buffers
// carry an embedded copy of the signature, which is sometimes spoilt by one
// byte, so that found and not-found results both turn up often. Now and then a
// register is rewritten part-way through a buffer, once the block is idle.
// Both sides of the block pause in short random bursts. The last phase runs
// with no pauses at all.
module masked_byte_signature_matcher_test;

  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned BYTES_PER_PHASE = 128;
  // The settle time covers the result register and a word still in flight.
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DRAIN_LIMIT     = 2000;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } match_result_t;

  typedef enum logic {ROW_REG_WRITE, ROW_BYTES} plan_kind_t;

  // One line of the directed table: either a register write, or a byte sent
  // one or more times. Rows marked fixed carry their expected result, and
  // that result applies to every repetition.
  typedef struct {
    plan_kind_t                       kind;
    logic [mbsm_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [mbsm_pkg::WORD_W-1:0]      reg_value;
    logic [7:0]                       data;
    logic                             last;
    int unsigned                      repeats;
    bit                               fixed;
    bit                               fixed_has;
    match_result_t                    fixed_result;
  } plan_row_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;   // [7:0] data_byte
  logic                           in_tlast   = 1'b0; // last_byte
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [31:0]                    out_tdata;         // [31:0] match_offset
  logic [0:0]                     out_tuser;         // [0] found
  logic                           cfg_we     = 1'b0;
  logic [mbsm_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [mbsm_pkg::WORD_W-1:0]    cfg_data   = '0;

  // Our copy of the registers and of the search state.
  logic [mbsm_pkg::WORD_W-1:0]   sig_low_copy;
  logic [mbsm_pkg::WORD_W-1:0]   sig_high_copy;
  logic [mbsm_pkg::CMP_EN_W-1:0] cmp_en_copy;
  logic [mbsm_pkg::LEN_W-1:0]    sig_len_copy;
  logic [7:0]                    history [mbsm_pkg::MAX_SIG_BYTES];
  logic [31:0]                   position;
  logic                          reported;

  match_result_t awaited_results[$];
  match_result_t oldest;
  int unsigned   mismatch_count = 0;
  int unsigned   in_gap_pct     = 0;
  int unsigned   out_stall_pct  = 0;
  int unsigned   ready_hold     = 0;

  masked_byte_signature_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic [7:0] signature_byte(input int unsigned i);
    if (i < 8) begin
      return sig_low_copy[8*i +: 8];
    end
    return sig_high_copy[8*(i-8) +: 8];
  endfunction

  // Advances our copy of the search by one byte and gives the result, if any.
  task automatic step_search(input logic [7:0] b, input logic l,
                             output bit has, output match_result_t res);
    int unsigned len;
    bit          hit;
    logic [31:0] cur;
    cur = position;
    has = 1'b0;
    res = '0;
    for (int k = mbsm_pkg::MAX_SIG_BYTES - 1; k > 0; k--) begin
      history[k] = history[k-1];
    end
    history[0] = b;
    if (!reported) begin
      len = (sig_len_copy > mbsm_pkg::MAX_SIG_BYTES) ? mbsm_pkg::MAX_SIG_BYTES :
            32'(sig_len_copy);
      hit = 1'b0;
      if (len == 0) begin
        hit = 1'b1;
      end else if (cur >= len - 1) begin
        hit = 1'b1;
        for (int unsigned i = 0; i < len; i++) begin
          if (cmp_en_copy[i] && signature_byte(i) != history[len-1-i]) begin
            hit = 1'b0;
          end
        end
        res.offset = cur - (len - 1);
      end
      if (hit) begin
        has       = 1'b1;
        res.found = 1'b1;
        reported  = 1'b1;
      end else if (l) begin
        has = 1'b1;
        res = '0;
      end
    end
    if (l) begin
      position = '0;
      reported = 1'b0;
      foreach (history[k]) begin
        history[k] = '0;
      end
    end else if (position != 32'hFFFF_FFFF) begin
      position++;
    end
  endtask

  // Presents one word, waits for it to be taken, then queues what it should
  // give. A fixed expectation, where given, replaces the model's own result.
  task automatic send_byte(input logic [7:0] b, input logic l, input bit fixed,
                           input bit fixed_has, input match_result_t fixed_res);
    bit            rdy;
    bit            has;
    match_result_t res;
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    // in_tready only moves just after a rising edge, so the falling edge is
    // a safe place to sample it.
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    step_search(b, l, has, res);
    if (fixed) begin
      has = fixed_has;
      res = fixed_res;
    end
    if (has) begin
      awaited_results.push_back(res);
    end
  endtask

  // Stops sending, then waits until every result has arrived and any byte
  // that gives no result has had time to pass through.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Raises the write enable and waits for a rising edge; the caller lowers it after the
  // last write of a group so that back-to-back writes need no second update.
  task automatic write_reg(input logic [mbsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mbsm_pkg::WORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      mbsm_pkg::CFG_SIG_LOW:  sig_low_copy  = val;
      mbsm_pkg::CFG_SIG_HIGH: sig_high_copy = val;
      mbsm_pkg::CFG_CMP_EN:   cmp_en_copy   = val[mbsm_pkg::CMP_EN_W-1:0];
      mbsm_pkg::CFG_SIG_LEN:  sig_len_copy  = val[mbsm_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic plan_row_t reg_row(input logic [mbsm_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [mbsm_pkg::WORD_W-1:0] val);
    plan_row_t r;
    r           = '{kind: ROW_REG_WRITE, default: '0};
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] b, input logic l,
                                         input int unsigned reps, input bit fixed,
                                         input bit has, input logic found,
                                         input logic [31:0] off);
    plan_row_t r;
    r                     = '{kind: ROW_BYTES, default: '0};
    r.data                = b;
    r.last                = l;
    r.repeats             = reps;
    r.fixed               = fixed;
    r.fixed_has           = has;
    r.fixed_result.found  = found;
    r.fixed_result.offset = off;
    return r;
  endfunction

  // The receiver drops its ready in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      ready_hold <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // A result word is taken at the next rising edge if valid and ready are
  // both high now, and it is checked here against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("result word with nothing awaited: found=%0b offset=%0d",
                                out_tuser[0], out_tdata));
      end else begin
        oldest = awaited_results.pop_front();
        if (out_tuser[0] !== oldest.found) begin
          note_mismatch($sformatf("found is %0b, awaited %0b", out_tuser[0], oldest.found));
        end
        if (out_tdata !== oldest.offset) begin
          note_mismatch($sformatf("match_offset is %0d, awaited %0d",
                                  out_tdata, oldest.offset));
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t                   plan[$];
    bit                          writing;
    logic [7:0]                  buffer_bytes[$];
    logic [mbsm_pkg::WORD_W-1:0] lo_val, hi_val, en_val, len_val;
    int unsigned                 eff, blen, at, split, sent;

    // The model starts from the same cleared state as the block after reset.
    sig_low_copy  = '0;
    sig_high_copy = '0;
    cmp_en_copy   = '0;
    sig_len_copy  = '0;
    foreach (history[k]) begin
      history[k] = '0;
    end
    position = '0;
    reported = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. With the registers cleared the signature is empty, so
    // the first byte matches at offset zero and the rest of the buffer,
    // final byte included, stays silent.
    plan.push_back(byte_row(8'h00, 1'b0, 1, 1'b1, 1'b1, 1'b1, 0));
    plan.push_back(byte_row(8'hFF, 1'b1, 1, 1'b1, 1'b0, 1'b0, 0));
    // A signature of "ABC", every byte compared: found at offset one.
    plan.push_back(reg_row(mbsm_pkg::CFG_SIG_LOW, 64'h0000_0000_0043_4241));
    plan.push_back(reg_row(mbsm_pkg::CFG_CMP_EN, 64'hFFFF));
    plan.push_back(reg_row(mbsm_pkg::CFG_SIG_LEN, 64'd3));
    plan.push_back(byte_row(8'h41, 1'b0, 2, 1'b1, 1'b0, 1'b0, 0));
    plan.push_back(byte_row(8'h42, 1'b0, 1, 1'b1, 1'b0, 1'b0, 0));
    plan.push_back(byte_row(8'h43, 1'b0, 1, 1'b1, 1'b1, 1'b1, 1));
    plan.push_back(byte_row(8'h41, 1'b1, 1, 1'b0, 1'b0, 1'b0, 0));
    // A match that would run past the end of the buffer is not a match.
    plan.push_back(byte_row(8'h41, 1'b0, 1, 1'b1, 1'b0, 1'b0, 0));
    plan.push_back(byte_row(8'h42, 1'b1, 1, 1'b1, 1'b1, 1'b0, 0));
    // A length of 31 is cut to sixteen. Only the outer bytes are compared, and
    // the match completes on the final byte, which gives no not-found result.
    plan.push_back(reg_row(mbsm_pkg::CFG_SIG_LOW, '1));
    plan.push_back(reg_row(mbsm_pkg::CFG_SIG_HIGH, '1));
    plan.push_back(reg_row(mbsm_pkg::CFG_CMP_EN, 64'h8001));
    plan.push_back(reg_row(mbsm_pkg::CFG_SIG_LEN, 64'd31));
    plan.push_back(byte_row(8'hFF, 1'b0, 1, 1'b1, 1'b0, 1'b0, 0));
    plan.push_back(byte_row(8'h00, 1'b0, 14, 1'b1, 1'b0, 1'b0, 0));
    plan.push_back(byte_row(8'hFF, 1'b1, 1, 1'b1, 1'b1, 1'b1, 0));

    in_gap_pct    = 20;
    out_stall_pct = 20;
    writing       = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG_WRITE) begin
        if (!writing) begin
          wait_idle();
        end
        write_reg(plan[r].reg_index, plan[r].reg_value);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
        end
        writing = 1'b0;
        repeat (plan[r].repeats) begin
          send_byte(plan[r].data, plan[r].last, plan[r].fixed, plan[r].fixed_has,
                    plan[r].fixed_result);
        end
      end
    end

    // Random phases. The first four pin the registers to their extremes.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      lo_val  = {$urandom(), $urandom()};
      hi_val  = {$urandom(), $urandom()};
      en_val  = 64'($urandom_range(0, 16'hFFFF));
      len_val = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 31)) :
                64'($urandom_range(1, 6));
      case (phase)
        0: begin
          lo_val  = '0;
          hi_val  = '0;
          en_val  = '0;
          len_val = '0;
        end
        1: begin
          lo_val  = '1;
          hi_val  = '1;
          en_val  = 64'hFFFF;
          len_val = 64'(mbsm_pkg::MAX_SIG_BYTES);
        end
        2: begin
          en_val  = 64'hFFFF;
          len_val = 64'd31;
        end
        3: begin
          en_val  = '0;
          len_val = 64'd1;
        end
        default: ;
      endcase
      wait_idle();
      write_reg(mbsm_pkg::CFG_SIG_LOW, lo_val);
      write_reg(mbsm_pkg::CFG_SIG_HIGH, hi_val);
      write_reg(mbsm_pkg::CFG_CMP_EN, en_val);
      write_reg(mbsm_pkg::CFG_SIG_LEN, len_val);
      cfg_we <= 1'b0;

      // Pressure varies from phase to phase; the closing phase runs flat out.
      if (phase == RANDOM_PHASES - 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end

      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        eff  = (sig_len_copy > mbsm_pkg::MAX_SIG_BYTES) ? mbsm_pkg::MAX_SIG_BYTES :
               32'(sig_len_copy);
        blen = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
        // Background bytes lean towards the signature's own bytes so that
        // near misses are common.
        buffer_bytes.delete();
        for (int unsigned i = 0; i < blen; i++) begin
          if ($urandom_range(0, 1) == 1) begin
            buffer_bytes.push_back(
                signature_byte($urandom_range(0, mbsm_pkg::MAX_SIG_BYTES - 1)));
          end else begin
            buffer_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        if (eff != 0 && eff <= blen && $urandom_range(0, 9) < 6) begin
          at = $urandom_range(0, blen - eff);
          for (int unsigned i = 0; i < eff; i++) begin
            if (cmp_en_copy[i]) begin
              buffer_bytes[at+i] = signature_byte(i);
            end
          end
          // Sometimes one byte of the copy is spoilt.
          if ($urandom_range(0, 3) == 0) begin
            buffer_bytes[at + $urandom_range(0, eff - 1)] ^= 8'($urandom_range(1, 255));
          end
        end
        // Occasionally one register is rewritten part-way through the buffer.
        split = (blen > 1 && $urandom_range(0, 11) == 0) ? $urandom_range(1, blen - 1) : blen;
        for (int unsigned i = 0; i < blen; i++) begin
          if (i == split) begin
            wait_idle();
            write_reg(mbsm_pkg::CFG_IDX_W'($urandom_range(0, 3)), {$urandom(), $urandom()});
            cfg_we <= 1'b0;
          end
          send_byte(buffer_bytes[i], i == blen - 1, 1'b0, 1'b0, '0);
        end
        sent += blen;
      end
    end

    in_tvalid <= 1'b0;
    for (int unsigned w = 0; w < DRAIN_LIMIT && awaited_results.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mbsm_pkg.sv
design/mbsm_cell.sv
design/masked_byte_signature_matcher.sv
design/mbsm_checker.sv
tb/sv/masked_byte_signature_matcher_test.sv
